### hdl/hbmv_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the histogram block.
package hbmv_pkg;

	localparam int MAX_GROUPS_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 24;

	localparam int LIM_BITS   = 16;
	localparam int GC_BITS    = 5;
	localparam int FRAC_BITS  = 17;
	localparam int FRAC_SHIFT = 16;
	localparam int MEAN_BITS  = 16;
	localparam int VAR_BITS   = 31;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;
	localparam int LANES      = 4;

	localparam int      MEAN_MAX = 32767;
	localparam int      MEAN_MIN = -32768;
	localparam longint  VAR_MAX  = 64'd2147483647;

	localparam logic [LIM_BITS-1:0] LOW_RST    = 16'd0;
	localparam logic [LIM_BITS-1:0] HIGH_RST   = 16'd32767;
	localparam logic [GC_BITS-1:0]  GROUPS_RST = 5'd10;

	// operation codes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// register indexes (paddr word address)
	localparam logic [1:0] REG_LOW    = 2'd0;
	localparam logic [1:0] REG_HIGH   = 2'd1;
	localparam logic [1:0] REG_GROUPS = 2'd2;

	typedef enum logic [1:0] {
		DIV_FRAC,
		DIV_MEAN,
		DIV_MSQ
	} div_sel_t;

	typedef struct packed {
		logic     smp_load;
		logic     srch_step;
		logic     bin_upd;
		logic     drop;
		logic     clr_all;
		logic     idx_clr;
		logic     idx_inc;
		logic     rd_load;
		logic     res_zero;
		logic     div_start;
		div_sel_t start_sel;
		logic     div_store;
		div_sel_t store_sel;
		logic     mm_calc;
		logic     var_calc;
		logic     out_load;
	} hbmv_cmd_t;

	typedef struct packed {
		logic full;
		logic srch_done;
		logic div_done;
		logic bin_empty;
		logic idx_last;
		logic out_free;
	} hbmv_sts_t;

endpackage

### hdl/histogram_bin_mean_variance.sv
`timescale 1ns / 1ps
// Top level: histogram with per-bin count, mean and variance.
//
//   channel   signals                              moves
//   config    psel penable pwrite paddr pwdata     low_limit, high_limit, group_count
//   request   req_valid req_ready                  operation, sample
//   response  rsp_valid rsp_ready                  one bin result per transaction
//
// Add: accept, search (four bin edges compared per cycle), then accumulate into the bin.
// Clear and an overflowing add finish in the accept step, with no search or accumulate.
// Readout: per non-empty bin, the fraction, mean and mean square are divided in turn on
// the one-bit-per-cycle divider that they share; empty bins skip the divider.
// A stalled response holds the sequencer in its emit step; requests are taken
// only while no add or readout is in progress. Reset clears all bins at once.
module histogram_bin_mean_variance
	import hbmv_pkg::*;
#(
	parameter int MAX_GROUPS  = MAX_GROUPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	localparam int BIN_BITS   = $clog2(MAX_GROUPS + 2)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [APB_AW-1:0]             paddr,
	input  logic [APB_DW-1:0]             pwdata,
	output logic [APB_DW-1:0]             prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [1:0]                    operation,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [BIN_BITS-1:0]           bin_index,
	output logic [COUNT_BITS-1:0]         bin_count,
	output logic [FRAC_BITS-1:0]          bin_fraction,
	output logic signed [MEAN_BITS-1:0]   bin_mean,
	output logic [VAR_BITS-1:0]           bin_variance,
	output logic                          overflowed,
	output logic                          last_bin
);

	logic signed [LIM_BITS-1:0] low_q;
	logic signed [LIM_BITS-1:0] high_q;
	logic [GC_BITS-1:0]         groups_q;
	hbmv_cmd_t                  cmd;
	hbmv_sts_t                  sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= LOW_RST;
			high_q   <= HIGH_RST;
			groups_q <= GROUPS_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_LOW:    low_q    <= pwdata[LIM_BITS-1:0];
				REG_HIGH:   high_q   <= pwdata[LIM_BITS-1:0];
				REG_GROUPS: groups_q <= pwdata[GC_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LOW:    prdata = {{(APB_DW-LIM_BITS){1'b0}}, low_q};
			REG_HIGH:   prdata = {{(APB_DW-LIM_BITS){1'b0}}, high_q};
			REG_GROUPS: prdata = {{(APB_DW-GC_BITS){1'b0}}, groups_q};
			default:    prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	hbmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.operation(operation),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hbmv_dp #(
		.MAX_GROUPS (MAX_GROUPS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample      (sample),
		.low_limit   (low_q),
		.high_limit  (high_q),
		.group_count (groups_q),
		.rsp_ready   (rsp_ready),
		.rsp_valid   (rsp_valid),
		.bin_index   (bin_index),
		.bin_count   (bin_count),
		.bin_fraction(bin_fraction),
		.bin_mean    (bin_mean),
		.bin_variance(bin_variance),
		.overflowed  (overflowed),
		.last_bin    (last_bin)
	);

endmodule

### hdl/hbmv_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module hbmv_div
	import hbmv_pkg::*;
#(
	parameter int DW = 56,
	parameter int SW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [SW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          busy,
	output logic          done
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [SW:0]   r2;
	logic          ge;
	logic [SW:0]   rn;

	always_comb begin
		r2 = {rem_q, quo_q[DW-1]};
		ge = r2 >= {1'b0, dvs_q};
		rn = ge ? (r2 - {1'b0, dvs_q}) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= rn[SW-1:0];
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

### hdl/hbmv_dp.sv
`timescale 1ns / 1ps
// Datapath: bin search, bin accumulators, readout arithmetic and result register.
module hbmv_dp
	import hbmv_pkg::*;
#(
	parameter int MAX_GROUPS  = MAX_GROUPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	localparam int NBINS      = MAX_GROUPS + 2,
	localparam int BIN_BITS   = $clog2(NBINS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hbmv_cmd_t                     cmd,
	output hbmv_sts_t                     sts,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [LIM_BITS-1:0]    low_limit,
	input  logic signed [LIM_BITS-1:0]    high_limit,
	input  logic [GC_BITS-1:0]            group_count,
	input  logic                          rsp_ready,
	output logic                          rsp_valid,
	output logic [BIN_BITS-1:0]           bin_index,
	output logic [COUNT_BITS-1:0]         bin_count,
	output logic [FRAC_BITS-1:0]          bin_fraction,
	output logic signed [MEAN_BITS-1:0]   bin_mean,
	output logic [VAR_BITS-1:0]           bin_variance,
	output logic                          overflowed,
	output logic                          last_bin
);

	localparam int SB       = SAMPLE_BITS;
	localparam int CB       = COUNT_BITS;
	localparam int SUM_BITS = SB + CB;
	localparam int SQ_BITS  = 2 * SB + CB;
	localparam int DW       = SQ_BITS;
	localparam int EXT_BITS = ((SB > LIM_BITS) ? SB : LIM_BITS) + 2;
	localparam int TW       = EXT_BITS + BIN_BITS + 2;
	localparam int KW       = BIN_BITS + 3;
	localparam int MB       = SB + 1;
	localparam int VW       = ((DW + 1) > (VAR_BITS + 2)) ? (DW + 1) : (VAR_BITS + 2);

	// bin storage
	logic [CB-1:0]              cnt_q [NBINS];
	logic signed [SUM_BITS-1:0] sum_q [NBINS];
	logic [SQ_BITS-1:0]         sqs_q [NBINS];
	logic [CB-1:0]              total_q;
	logic                       ovf_q;
	logic [BIN_BITS-1:0]        idx_q;

	// add path
	logic [BIN_BITS-1:0]        n_w;
	logic signed [TW-1:0]       dx;
	logic signed [TW-1:0]       nx;
	logic signed [TW-1:0]       sx;
	logic signed [2*SB-1:0]     sprod;
	logic signed [SB-1:0]       s_s1;
	logic signed [TW-1:0]       t_s1;
	logic [2*SB-1:0]            sq_s1;
	logic signed [TW-1:0]       acc_q;
	logic [KW-1:0]              k_q;
	logic [KW-1:0]              kj;
	logic                       hit;
	logic [KW-1:0]              hit_k;
	logic                       exhaust;
	logic [BIN_BITS-1:0]        found_bin;

	// readout path
	logic [CB-1:0]              wc_q;
	logic signed [SUM_BITS-1:0] ws_q;
	logic [SQ_BITS-1:0]         wq_q;
	logic [SUM_BITS-1:0]        sum_mag;
	logic [CB-1:0]              tot_safe;
	logic [DW-1:0]              dvd;
	logic [CB-1:0]              dvs;
	logic [DW-1:0]              quo;
	logic                       div_busy;
	logic                       div_done;
	logic [MB-1:0]              mq;
	logic [FRAC_BITS-1:0]       frac_q;
	logic signed [MB-1:0]       mean_q;
	logic [DW-1:0]              msq_q;
	logic [2*MB-1:0]            mm_q;
	logic [VAR_BITS-1:0]        var_q;
	logic signed [VW-1:0]       diff;
	logic signed [31:0]         mean_ext;
	logic signed [31:0]         mean_sat;

	// result register
	logic                       rsp_valid_q;
	logic [BIN_BITS-1:0]        bin_index_q;
	logic [CB-1:0]              bin_count_q;
	logic [FRAC_BITS-1:0]       bin_fraction_q;
	logic signed [MEAN_BITS-1:0] bin_mean_q;
	logic [VAR_BITS-1:0]        bin_variance_q;
	logic                       overflowed_q;
	logic                       last_bin_q;

	always_comb begin
		if (group_count == '0)
			n_w = BIN_BITS'(1);
		else if (8'(group_count) > 8'(MAX_GROUPS))
			n_w = BIN_BITS'(MAX_GROUPS);
		else
			n_w = BIN_BITS'(group_count);
	end

	// Inner bin k is taken when (s - low + 1) * n <= (high - low) * k.
	always_comb begin
		dx    = TW'(high_limit) - TW'(low_limit);
		nx    = TW'($signed({1'b0, n_w}));
		sx    = TW'(sample) - TW'(low_limit) + TW'(1);
		sprod = sample * sample;
	end

	always_comb begin
		hit   = 1'b0;
		hit_k = '0;
		kj    = '0;
		for (int j = LANES - 1; j >= 0; j--) begin
			kj = k_q + KW'(j);
			if ((kj < KW'(n_w)) && (t_s1 <= acc_q + dx * TW'(j))) begin
				hit   = 1'b1;
				hit_k = kj;
			end
		end
		exhaust = (k_q + KW'(LANES)) >= KW'(n_w);
		if (hit)
			found_bin = BIN_BITS'(hit_k);
		else if (s_s1 <= high_limit)
			found_bin = n_w;
		else
			found_bin = n_w + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.smp_load) begin
			s_s1  <= sample;
			t_s1  <= TW'(sx * nx);
			sq_s1 <= $unsigned(sprod);
			acc_q <= '0;
			k_q   <= '0;
		end else if (cmd.srch_step && !(hit || exhaust)) begin
			acc_q <= acc_q + dx * TW'(LANES);
			k_q   <= k_q + KW'(LANES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NBINS; b++) begin
				cnt_q[b] <= '0;
				sum_q[b] <= '0;
				sqs_q[b] <= '0;
			end
			total_q <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (cmd.clr_all) begin
				for (int b = 0; b < NBINS; b++) begin
					cnt_q[b] <= '0;
					sum_q[b] <= '0;
					sqs_q[b] <= '0;
				end
				total_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.bin_upd) begin
				cnt_q[idx_q] <= cnt_q[idx_q] + 1'b1;
				sum_q[idx_q] <= sum_q[idx_q] + SUM_BITS'(s_s1);
				sqs_q[idx_q] <= sqs_q[idx_q] + SQ_BITS'(sq_s1);
				total_q      <= total_q + 1'b1;
			end else if (cmd.drop) begin
				ovf_q <= 1'b1;
			end
			if (cmd.srch_step && (hit || exhaust))
				idx_q <= found_bin;
			else if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + 1'b1;
		end
	end

	always_comb begin
		sum_mag  = ws_q[SUM_BITS-1] ? (~ws_q + 1'b1) : ws_q;
		tot_safe = (total_q == '0) ? CB'(1) : total_q;
		case (cmd.start_sel)
			DIV_FRAC: begin
				dvd = DW'({wc_q, {FRAC_SHIFT{1'b0}}});
				dvs = tot_safe;
			end
			DIV_MEAN: begin
				dvd = DW'(sum_mag);
				dvs = wc_q;
			end
			DIV_MSQ: begin
				dvd = wq_q;
				dvs = wc_q;
			end
			default: begin
				dvd = wq_q;
				dvs = wc_q;
			end
		endcase
	end

	hbmv_div #(
		.DW(DW),
		.SW(CB)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dvd),
		.divisor (dvs),
		.quotient(quo),
		.busy    (div_busy),
		.done    (div_done)
	);

	always_comb begin
		mq   = quo[MB-1:0];
		diff = VW'($signed({1'b0, msq_q})) - VW'($signed({1'b0, mm_q}));
		mean_ext = 32'(mean_q);
		if (mean_ext > MEAN_MAX)
			mean_sat = MEAN_MAX;
		else if (mean_ext < MEAN_MIN)
			mean_sat = MEAN_MIN;
		else
			mean_sat = mean_ext;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_load) begin
			wc_q <= cnt_q[idx_q];
			ws_q <= sum_q[idx_q];
			wq_q <= sqs_q[idx_q];
		end
		if (cmd.res_zero) begin
			frac_q <= '0;
			mean_q <= '0;
			var_q  <= '0;
		end
		if (cmd.div_store) begin
			case (cmd.store_sel)
				DIV_FRAC: frac_q <= quo[FRAC_BITS-1:0];
				DIV_MEAN: mean_q <= ws_q[SUM_BITS-1] ? -$signed(mq) : $signed(mq);
				DIV_MSQ:  msq_q  <= quo;
				default:  msq_q  <= quo;
			endcase
		end
		// square at full width; the operands are widened before the multiply
		if (cmd.mm_calc)
			mm_q <= $unsigned((2*MB)'(mean_q) * (2*MB)'(mean_q));
		if (cmd.var_calc) begin
			if (diff < 0)
				var_q <= '0;
			else if (diff > VW'(VAR_MAX))
				var_q <= VAR_BITS'(VAR_MAX);
			else
				var_q <= VAR_BITS'(diff);
		end
		if (cmd.out_load) begin
			bin_index_q    <= idx_q;
			bin_count_q    <= wc_q;
			bin_fraction_q <= frac_q;
			bin_mean_q     <= MEAN_BITS'(mean_sat);
			bin_variance_q <= var_q;
			overflowed_q   <= ovf_q;
			last_bin_q     <= sts.idx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (cmd.out_load)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_comb begin
		sts.full      = (total_q == {CB{1'b1}});
		sts.srch_done = hit || exhaust;
		sts.div_done  = div_done;
		sts.bin_empty = (wc_q == '0);
		sts.idx_last  = (idx_q == n_w + 1'b1);
		sts.out_free  = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid    = rsp_valid_q;
	assign bin_index    = bin_index_q;
	assign bin_count    = bin_count_q;
	assign bin_fraction = bin_fraction_q;
	assign bin_mean     = bin_mean_q;
	assign bin_variance = bin_variance_q;
	assign overflowed   = overflowed_q;
	assign last_bin     = last_bin_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten before transaction");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_all |=> (total_q == '0 && !ovf_q))
		else $error("bins not cleared");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bin_upd |-> ({1'b0, idx_q} <= {1'b0, n_w} + 1'b1))
		else $error("bin index past active range");

endmodule

### hdl/hbmv_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences add, clear and per-bin readout over the datapath.
module hbmv_ctrl
	import hbmv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] operation,
	output logic       req_ready,
	input  hbmv_sts_t  sts,
	output hbmv_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_UPDATE,
		S_RD_LOAD,
		S_RD_CHECK,
		S_DIV_F,
		S_DIV_M,
		S_DIV_Q,
		S_MM,
		S_VAR,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (operation)
						OP_ADD: begin
							if (sts.full) begin
								cmd.drop = 1'b1;
							end else begin
								cmd.smp_load = 1'b1;
								state_d      = S_SEARCH;
							end
						end
						OP_READ: begin
							cmd.idx_clr = 1'b1;
							state_d     = S_RD_LOAD;
						end
						OP_CLEAR: cmd.clr_all = 1'b1;
						default: ;
					endcase
				end
			end
			S_SEARCH: begin
				cmd.srch_step = 1'b1;
				if (sts.srch_done)
					state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.bin_upd = 1'b1;
				state_d     = S_IDLE;
			end
			S_RD_LOAD: begin
				cmd.rd_load = 1'b1;
				state_d     = S_RD_CHECK;
			end
			S_RD_CHECK: begin
				if (sts.bin_empty) begin
					cmd.res_zero = 1'b1;
					state_d      = S_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.start_sel = DIV_FRAC;
					state_d       = S_DIV_F;
				end
			end
			S_DIV_F: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					cmd.store_sel = DIV_FRAC;
					cmd.div_start = 1'b1;
					cmd.start_sel = DIV_MEAN;
					state_d       = S_DIV_M;
				end
			end
			S_DIV_M: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					cmd.store_sel = DIV_MEAN;
					cmd.div_start = 1'b1;
					cmd.start_sel = DIV_MSQ;
					state_d       = S_DIV_Q;
				end
			end
			S_DIV_Q: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					cmd.store_sel = DIV_MSQ;
					state_d       = S_MM;
				end
			end
			S_MM: begin
				cmd.mm_calc = 1'b1;
				state_d     = S_VAR;
			end
			S_VAR: begin
				cmd.var_calc = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.idx_last) begin
						cmd.clr_all = 1'b1;
						state_d     = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_RD_LOAD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign req_ready = (state_q == S_IDLE);

endmodule
